/* hw/rtl/jeti_pkg.sv */
// ----------------------------------------------------------------------------
// jeti_pkg: shared definitions for the Julia escape-time iterator
// Image size, register indexes, power mode codes, the configuration
// bundle and the saturation helper used by the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jeti_pkg;

  localparam int IMAGE_WIDTH  = 1024;
  localparam int IMAGE_HEIGHT = 1024;

  localparam int FRAC_BITS = 24;

  localparam logic signed [47:0] IMAGE_WIDTH_S  = 48'(IMAGE_WIDTH);
  localparam logic signed [47:0] IMAGE_HEIGHT_S = 48'(IMAGE_HEIGHT);
  localparam logic signed [47:0] TWO_Q24        = 48'sd2 <<< FRAC_BITS;
  localparam logic [64:0]        ESCAPE_Q48     = 65'd4 << 48;

  typedef enum logic [2:0] {
    REG_INVERSE_ZOOM     = 3'd0,
    REG_HORIZONTAL_SHIFT = 3'd1,
    REG_VERTICAL_SHIFT   = 3'd2,
    REG_CONSTANT_REAL    = 3'd3,
    REG_CONSTANT_IMAG    = 3'd4,
    REG_ITERATION_LIMIT  = 3'd5,
    REG_POWER_MODE       = 3'd6
  } reg_index_t;

  localparam logic [1:0] MODE_SQUARE = 2'd0;
  localparam logic [1:0] MODE_CUBE   = 2'd1;
  localparam logic [1:0] MODE_FOURTH = 2'd2;

  typedef struct packed {
    logic        [30:0] inverse_zoom;
    logic signed [20:0] horizontal_shift;
    logic signed [20:0] vertical_shift;
    logic signed [31:0] constant_real;
    logic signed [31:0] constant_imag;
    logic        [15:0] iteration_limit;
    logic        [1:0]  power_mode;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/julia_escape_time_iterator_top.sv */
// ----------------------------------------------------------------------------
// julia_escape_time_iterator_top: escape-time iterator for z = z^k + c
// Maps a pixel into the complex plane and counts iterations until escape.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel beat (pixel_col, pixel_row) is taken on a rising edge with start
//   high and busy low. busy stays high until the pixel is finished.
//   The result beat, iteration_count, is shown for one cycle with done high;
//   the receiver cannot stall it, and a new start is taken in that cycle.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
//   and are to be made only while the block is idle; the block does not enforce it.
// Sequencing:
//   Every multiply goes through the single shared 32 by 32 multiplier, so the
//   products of each pass are formed one after another. Mapping steps through
//   S_MAPX, S_MAPY and S_MAPW; each pass of the loop steps through S_LOOP,
//   S_XX, S_YY, S_XY and S_CHK, followed by S_C1 to S_C3 for z^3 or S_Q1 to
//   S_Q5 for z^4 unless the pixel escaped. The block handles one pixel at a time.
// Reset:
//   rst is synchronous; it returns the sequencer to idle and loads the
//   register defaults (zoom 1.0, no pan, c = 0, limit 64, z^2).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module julia_escape_time_iterator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [9:0]  pixel_col,
  input  wire logic [9:0]  pixel_row,
  output      logic        done,
  output      logic [15:0] iteration_count,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_MAPX = 17'h00002,
    S_MAPY = 17'h00004,
    S_MAPW = 17'h00008,
    S_LOOP = 17'h00010,
    S_XX   = 17'h00020,
    S_YY   = 17'h00040,
    S_XY   = 17'h00080,
    S_CHK  = 17'h00100,
    S_C1   = 17'h00200,
    S_C2   = 17'h00400,
    S_C3   = 17'h00800,
    S_Q1   = 17'h01000,
    S_Q2   = 17'h02000,
    S_Q3   = 17'h04000,
    S_Q4   = 17'h08000,
    S_Q5   = 17'h10000
  } state_t;

  jeti_pkg::cfg_t cfg;

  state_t             state, state_next;
  logic        [9:0]  col, row;
  logic signed [31:0] x, y;
  logic signed [63:0] xx, yy;
  logic        [25:0] x2, y2;
  logic signed [31:0] xy;
  logic signed [63:0] acc;
  logic        [15:0] count;

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;

  logic        [35:0] tx_q, ty_q;
  logic signed [31:0] tx, ty;
  logic signed [47:0] sx, sy;
  logic signed [31:0] izs;
  logic signed [31:0] cube_a, cube_b, four_d;
  logic signed [31:0] x2s, y2s;
  logic        [64:0] mag;
  logic               escaped;
  logic signed [47:0] cr, ci;
  logic signed [63:0] prod6;

  jeti_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jeti_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    tx_q = 36'({col, 26'b0} / 36'(jeti_pkg::IMAGE_WIDTH));
    ty_q = 36'({row, 26'b0} / 36'(jeti_pkg::IMAGE_HEIGHT));
    tx   = jeti_pkg::sat32($signed({12'b0, tx_q}) - jeti_pkg::TWO_Q24);
    ty   = jeti_pkg::sat32($signed({12'b0, ty_q}) - jeti_pkg::TWO_Q24);
    sx   = 48'((48'(cfg.horizontal_shift) <<< jeti_pkg::FRAC_BITS)
               / jeti_pkg::IMAGE_WIDTH_S);
    sy   = 48'((48'(cfg.vertical_shift) <<< jeti_pkg::FRAC_BITS)
               / jeti_pkg::IMAGE_HEIGHT_S);
    izs  = $signed({1'b0, cfg.inverse_zoom});
    x2s  = $signed({6'b0, x2});
    y2s  = $signed({6'b0, y2});
    cube_a = x2s - 32'(3 * y2s);
    cube_b = 32'(3 * x2s) - y2s;
    four_d = x2s - y2s;
    mag     = {1'b0, xx} + {1'b0, yy};
    escaped = (mag >= jeti_pkg::ESCAPE_Q48);
    cr    = 48'(cfg.constant_real);
    ci    = 48'(cfg.constant_imag);
    prod6 = (prod <<< 2) + (prod <<< 1);
  end

  always_comb begin
    op_a = x;
    op_b = x;
    case (state)
      S_MAPX: begin
        op_a = tx;
        op_b = izs;
      end
      S_MAPY: begin
        op_a = ty;
        op_b = izs;
      end
      S_YY: begin
        op_a = y;
        op_b = y;
      end
      S_XY: begin
        op_a = x;
        op_b = y;
      end
      S_C1: begin
        op_a = x;
        op_b = cube_a;
      end
      S_C2: begin
        op_a = y;
        op_b = cube_b;
      end
      S_Q1: begin
        op_a = x2s;
        op_b = x2s;
      end
      S_Q2: begin
        op_a = y2s;
        op_b = y2s;
      end
      S_Q3: begin
        op_a = x2s;
        op_b = y2s;
      end
      S_Q4: begin
        op_a = xy;
        op_b = four_d;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_MAPX;
      S_MAPX: state_next = S_MAPY;
      S_MAPY: state_next = S_MAPW;
      S_MAPW: state_next = S_LOOP;
      S_LOOP: state_next = (count >= cfg.iteration_limit) ? S_IDLE : S_XX;
      S_XX:   state_next = S_YY;
      S_YY:   state_next = S_XY;
      S_XY:   state_next = S_CHK;
      S_CHK: begin
        if (escaped) begin
          state_next = S_IDLE;
        end else if (cfg.power_mode == jeti_pkg::MODE_CUBE) begin
          state_next = S_C1;
        end else if (cfg.power_mode == jeti_pkg::MODE_FOURTH) begin
          state_next = S_Q1;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_C1:   state_next = S_C2;
      S_C2:   state_next = S_C3;
      S_C3:   state_next = S_LOOP;
      S_Q1:   state_next = S_Q2;
      S_Q2:   state_next = S_Q3;
      S_Q3:   state_next = S_Q4;
      S_Q4:   state_next = S_Q5;
      S_Q5:   state_next = S_LOOP;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == S_LOOP) && (count >= cfg.iteration_limit)) ||
               ((state == S_CHK) && escaped);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          col   <= pixel_col;
          row   <= pixel_row;
          count <= '0;
        end
      end
      S_MAPY: x <= jeti_pkg::sat32(48'(prod >>> jeti_pkg::FRAC_BITS) + sx);
      S_MAPW: y <= jeti_pkg::sat32(48'(prod >>> jeti_pkg::FRAC_BITS) + sy);
      S_YY:   xx <= prod;
      S_XY:   yy <= prod;
      S_CHK: begin
        x2 <= xx[49:24];
        y2 <= yy[49:24];
        xy <= 32'(prod >>> jeti_pkg::FRAC_BITS);
        if (!escaped && cfg.power_mode != jeti_pkg::MODE_CUBE &&
            cfg.power_mode != jeti_pkg::MODE_FOURTH) begin
          x     <= jeti_pkg::sat32(48'((xx - yy) >>> jeti_pkg::FRAC_BITS) + cr);
          y     <= jeti_pkg::sat32(48'(prod >>> (jeti_pkg::FRAC_BITS - 1)) + ci);
          count <= count + 16'd1;
        end
      end
      S_C2: acc <= prod;
      S_C3: begin
        x     <= jeti_pkg::sat32(48'(acc >>> jeti_pkg::FRAC_BITS) + cr);
        y     <= jeti_pkg::sat32(48'(prod >>> jeti_pkg::FRAC_BITS) + ci);
        count <= count + 16'd1;
      end
      S_Q2: acc <= prod;
      S_Q3: acc <= acc + prod;
      S_Q4: acc <= acc - prod6;
      S_Q5: begin
        x     <= jeti_pkg::sat32(48'(acc >>> jeti_pkg::FRAC_BITS) + cr);
        y     <= jeti_pkg::sat32(48'(prod >>> (jeti_pkg::FRAC_BITS - 2)) + ci);
        count <= count + 16'd1;
      end
      default: begin
      end
    endcase
  end

  assign iteration_count = count;

endmodule

`default_nettype wire

/* hw/rtl/jeti_cfg.sv */
// ----------------------------------------------------------------------------
// jeti_cfg: configuration register file
// Holds the zoom, pan, Julia constant, iteration limit and power mode.
// Writes to indexes beyond the register list are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jeti_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output jeti_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inverse_zoom     <= 31'd16777216;
      cfg.horizontal_shift <= '0;
      cfg.vertical_shift   <= '0;
      cfg.constant_real    <= '0;
      cfg.constant_imag    <= '0;
      cfg.iteration_limit  <= 16'd64;
      cfg.power_mode       <= jeti_pkg::MODE_SQUARE;
    end else if (cfg_write) begin
      case (jeti_pkg::reg_index_t'(cfg_index))
        jeti_pkg::REG_INVERSE_ZOOM:     cfg.inverse_zoom     <= cfg_data[30:0];
        jeti_pkg::REG_HORIZONTAL_SHIFT: cfg.horizontal_shift <= cfg_data[20:0];
        jeti_pkg::REG_VERTICAL_SHIFT:   cfg.vertical_shift   <= cfg_data[20:0];
        jeti_pkg::REG_CONSTANT_REAL:    cfg.constant_real    <= cfg_data;
        jeti_pkg::REG_CONSTANT_IMAG:    cfg.constant_imag    <= cfg_data;
        jeti_pkg::REG_ITERATION_LIMIT:  cfg.iteration_limit  <= cfg_data[15:0];
        jeti_pkg::REG_POWER_MODE:       cfg.power_mode       <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/jeti_mul.sv */
// ----------------------------------------------------------------------------
// jeti_mul: shared signed multiplier
// One 32 by 32 signed multiply per cycle with a registered 64-bit product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jeti_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] op_a,
  input  wire logic signed [31:0] op_b,
  output      logic signed [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

`default_nettype wire

/* test/tb_julia_escape_time_iterator_top.sv */
// ----------------------------------------------------------------------------
// tb_julia_escape_time_iterator_top: self-checking bench for the Julia iterator
// Pixel beats are sent under start/busy while configuration is rewritten
// between phases. A scoreboard class computes the escape count of every
// accepted pixel in fixed point and checks each done beat against it in order.
// A directed part covers the register extremes and the unused mode, the zero
// limit, the zero zoom and the unused register index. It is followed by
// randomized phases with random gaps on start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_julia_escape_time_iterator_top;
  import jeti_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 20_000_000;
  localparam int          RANDOM_PHASES    = 15;
  localparam int          PIXELS_PER_PHASE = 90;
  localparam int          QUIET_PHASES     = 3;
  localparam int          DRAIN_CYCLES     = 20;
  localparam logic [2:0]  REG_UNUSED       = 3'd7;
  localparam logic [1:0]  MODE_UNUSED      = 2'd3;
  localparam int          ONE_Q24          = 32'sh0100_0000;
  localparam int          INT32_MIN        = 32'sh8000_0000;
  localparam int          INT32_MAX        = 32'sh7FFF_FFFF;

  class count_scoreboard;
    cfg_t        cfg;
    logic [15:0] due_counts[$];
    int          mismatches;

    function new();
      cfg.inverse_zoom     = 31'h0100_0000;
      cfg.horizontal_shift = '0;
      cfg.vertical_shift   = '0;
      cfg.constant_real    = '0;
      cfg.constant_imag    = '0;
      cfg.iteration_limit  = 16'd64;
      cfg.power_mode       = MODE_SQUARE;
      mismatches           = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_INVERSE_ZOOM:     cfg.inverse_zoom     = data[30:0];
        REG_HORIZONTAL_SHIFT: cfg.horizontal_shift = data[20:0];
        REG_VERTICAL_SHIFT:   cfg.vertical_shift   = data[20:0];
        REG_CONSTANT_REAL:    cfg.constant_real    = data;
        REG_CONSTANT_IMAG:    cfg.constant_imag    = data;
        REG_ITERATION_LIMIT:  cfg.iteration_limit  = data[15:0];
        REG_POWER_MODE:       cfg.power_mode       = data[1:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > longint'(INT32_MAX)) return longint'(INT32_MAX);
      if (v < longint'(INT32_MIN)) return longint'(INT32_MIN);
      return v;
    endfunction

    function longint map_axis(logic [9:0] pix, longint dim, longint pan);
      longint t;
      longint p;
      longint s;
      t = clamp32((longint'(pix) <<< 26) / dim - (longint'(2) <<< FRAC_BITS));
      p = (t * longint'(cfg.inverse_zoom)) >>> FRAC_BITS;
      s = (pan * (longint'(1) <<< FRAC_BITS)) / dim;
      return clamp32(p + s);
    endfunction

    function logic [15:0] escape_count(logic [9:0] col, logic [9:0] row);
      longint      x;
      longint      y;
      longint      nx;
      longint      ny;
      longint      x2;
      longint      y2;
      longint      xy;
      int unsigned n;
      x = map_axis(col, IMAGE_WIDTH, $signed(cfg.horizontal_shift));
      y = map_axis(row, IMAGE_HEIGHT, $signed(cfg.vertical_shift));
      n = 0;
      while (n < cfg.iteration_limit) begin
        if ($unsigned(x * x) + $unsigned(y * y) >= (64'd4 << 48)) break;
        x2 = (x * x) >>> FRAC_BITS;
        y2 = (y * y) >>> FRAC_BITS;
        case (cfg.power_mode)
          MODE_CUBE: begin
            nx = (x * (x2 - 3 * y2)) >>> FRAC_BITS;
            ny = (y * (3 * x2 - y2)) >>> FRAC_BITS;
          end
          MODE_FOURTH: begin
            xy = (x * y) >>> FRAC_BITS;
            nx = (x2 * x2 + y2 * y2 - 6 * x2 * y2) >>> FRAC_BITS;
            ny = (4 * xy * (x2 - y2)) >>> FRAC_BITS;
          end
          default: begin
            nx = (x * x - y * y) >>> FRAC_BITS;
            ny = (2 * x * y) >>> FRAC_BITS;
          end
        endcase
        x = clamp32(nx + $signed(cfg.constant_real));
        y = clamp32(ny + $signed(cfg.constant_imag));
        n++;
      end
      return n[15:0];
    endfunction

    function void note_pixel(logic [9:0] col, logic [9:0] row);
      due_counts.push_back(escape_count(col, row));
    endfunction

    function void check_count(logic [15:0] got);
      logic [15:0] want;
      if (due_counts.size() == 0) begin
        $error("iteration_count: expected none, actual %0d", got);
        mismatches++;
        return;
      end
      want = due_counts.pop_front();
      if (got !== want) begin
        $error("iteration_count: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic [9:0]  pixel_col = '0;
  logic [9:0]  pixel_row = '0;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        busy;
  logic        done;
  logic [15:0] iteration_count;

  count_scoreboard board;
  int unsigned     cycle_count = 0;

  julia_escape_time_iterator_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .pixel_col       (pixel_col),
    .pixel_row       (pixel_row),
    .done            (done),
    .iteration_count (iteration_count),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && done === 1'b1) begin
      board.check_count(iteration_count);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_julia_escape_time_iterator_top failed");
    $finish;
  end

  function automatic cfg_t make_cfg(int zoom, int hpan, int vpan, int cre, int cim,
                                    int limit, logic [1:0] mode);
    cfg_t c;
    c.inverse_zoom     = zoom[30:0];
    c.horizontal_shift = hpan[20:0];
    c.vertical_shift   = vpan[20:0];
    c.constant_real    = cre;
    c.constant_imag    = cim;
    c.iteration_limit  = limit[15:0];
    c.power_mode       = mode;
    return c;
  endfunction

  function automatic logic signed [20:0] random_pan();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return -21'sd1048576;
    if (pick == 1) return 21'sd1048575;
    if (pick == 2) return 21'($urandom);
    return 21'(int'($urandom_range(0, 4096)) - 2048);
  endfunction

  function automatic logic signed [31:0] random_constant();
    int unsigned pick;
    pick = $urandom_range(0, 11);
    if (pick == 0) return INT32_MIN;
    if (pick == 1) return INT32_MAX;
    if (pick == 2) return $urandom;
    return int'($urandom_range(0, 2 * ONE_Q24)) - ONE_Q24;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t        c;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) c.inverse_zoom = 31'd1;
    else if (pick == 1) c.inverse_zoom = 31'h7FFF_FFFF;
    else if (pick == 2) c.inverse_zoom = 31'($urandom);
    else c.inverse_zoom = 31'($urandom_range(32'h0040_0000, 32'h0200_0000));
    c.horizontal_shift = random_pan();
    c.vertical_shift   = random_pan();
    c.constant_real    = random_constant();
    c.constant_imag    = random_constant();
    pick = $urandom_range(0, 9);
    if (pick == 0) c.iteration_limit = 16'd0;
    else if (pick == 1) c.iteration_limit = 16'($urandom_range(65, 255));
    else c.iteration_limit = 16'($urandom_range(1, 64));
    c.power_mode = 2'($urandom_range(0, 3));
    return c;
  endfunction

  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
    start     <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    board.note_pixel(col, row);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (board.due_counts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic apply_config(input cfg_t c);
    wait_idle();
    write_reg(REG_INVERSE_ZOOM, {1'($urandom), c.inverse_zoom});
    write_reg(REG_HORIZONTAL_SHIFT, {{11{c.horizontal_shift[20]}}, c.horizontal_shift});
    write_reg(REG_VERTICAL_SHIFT, {11'($urandom), c.vertical_shift});
    write_reg(REG_CONSTANT_REAL, c.constant_real);
    write_reg(REG_CONSTANT_IMAG, c.constant_imag);
    write_reg(REG_ITERATION_LIMIT, {16'($urandom), c.iteration_limit});
    write_reg(REG_POWER_MODE, {30'($urandom), c.power_mode});
    write_reg(REG_UNUSED, $urandom);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned gap_odds;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd341, 10'd682);

    // Zero zoom with the unused mode code: every pixel lands on the pan point.
    apply_config(make_cfg(0, -300, 150, -13421773, 2617246, 100, MODE_UNUSED));
    send_pixel(10'd5, 10'd900);
    send_pixel(10'd1000, 10'd20);
    send_pixel(10'd512, 10'd512);

    apply_config(make_cfg(INT32_MAX, -1048576, 1048575, INT32_MAX, INT32_MIN, 0,
                          MODE_CUBE));
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd700, 10'd300);

    apply_config(make_cfg(ONE_Q24, 0, 0, -12582912, 1677722, 40, MODE_CUBE));
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd600, 10'd400);
    send_pixel(10'd300, 10'd700);
    send_pixel(10'd100, 10'd950);

    apply_config(make_cfg(ONE_Q24, 0, 0, INT32_MAX, INT32_MIN, 50, MODE_FOURTH));
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd520, 10'd500);

    apply_config(make_cfg(ONE_Q24, 0, 0, 2516582, -9227469, 60, MODE_FOURTH));
    send_pixel(10'd256, 10'd768);
    send_pixel(10'd700, 10'd512);
    send_pixel(10'd400, 10'd400);

    apply_config(make_cfg(ONE_Q24, 0, 0, 0, 0, 65535, MODE_SQUARE));
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_config(random_cfg());
      gap_odds = (p < RANDOM_PHASES - QUIET_PHASES) ? $urandom_range(0, 3) : 0;
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        send_pixel(10'($urandom), 10'($urandom));
        if (gap_odds != 0 && $urandom_range(1, 4) <= gap_odds) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.due_counts.size() == 0) begin
      $display("tb_julia_escape_time_iterator_top passed");
    end else begin
      $display("tb_julia_escape_time_iterator_top failed");
    end
    $finish;
  end

endmodule
